>>> rtl/bdq_pkg.sv
// package for the bounded deque: item types, opcodes, status codes and defaults
`default_nettype none

package bdq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W       = 32;
  localparam int COUNT_W       = 7;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_DROP_FRONT = 3'd2;
  localparam logic [2:0] OP_DROP_BACK  = 3'd3;
  localparam logic [2:0] OP_COUNT      = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]                opcode;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [COUNT_W-1:0] match_count;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/bounded_deque_with_count.sv
// bounded double-ended queue over a ring memory, with a match count scan
`default_nettype none

// Holds up to DEPTH signed 32-bit values in a ring memory addressed by a front
// index and a fill count. Each cmd item pushes or drops at either end, or counts
// the stored entries equal to its value; every item gives exactly one rsp item.
// A push, a drop or an unused opcode passes through EXEC and DONE before the
// next acceptance. A count adds SCAN in between: the scan reads one entry
// per cycle through the single memory read port and compares it in a shared
// 32-bit comparator. cmd_stall is high while an item is in work; a finished rsp
// item waits in its output register, so the next item is taken meanwhile.
// Counts above 127 saturate at 127.
module bounded_deque_with_count
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  cmd_valid,
  output logic cmd_stall,
  input  wire cmd_t cmd,
  output logic rsp_valid,
  input  wire  rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]         state;
  logic [2:0]         op;
  logic [VALUE_W-1:0] key;
  logic [IDX_W-1:0]   front;
  logic [CNT_W-1:0]   fill;
  logic [IDX_W-1:0]   scan_pos;
  logic [CNT_W-1:0]   scan_cnt;
  logic               rd_pend;
  logic [VALUE_W-1:0] rd_data;
  logic [COUNT_W-1:0] hits;
  logic [1:0]         res_status;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic               full;
  logic               empty;
  logic [IDX_W-1:0]   front_dec;
  logic [IDX_W-1:0]   front_inc;
  logic [IDX_W-1:0]   scan_inc;
  logic [CNT_W:0]     back_sum;
  logic [IDX_W-1:0]   back_pos;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic               re;
  logic               out_free;

  assign full  = (fill == CNT_W'(DEPTH));
  assign empty = (fill == '0);

  assign front_dec = (front == '0) ? IDX_W'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == IDX_W'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign scan_inc  = (scan_pos == IDX_W'(DEPTH - 1)) ? '0 : scan_pos + 1'b1;

  assign back_sum = (CNT_W+1)'(front) + (CNT_W+1)'(fill);
  assign back_pos = (back_sum >= (CNT_W+1)'(DEPTH)) ?
                    IDX_W'(back_sum - (CNT_W+1)'(DEPTH)) : IDX_W'(back_sum);

  always_comb begin
    we    = 1'b0;
    waddr = back_pos;
    if (state == S_EXEC && !full) begin
      if (op == OP_PUSH_FRONT) begin
        we    = 1'b1;
        waddr = front_dec;
      end else if (op == OP_PUSH_BACK) begin
        we    = 1'b1;
        waddr = back_pos;
      end
    end
  end

  assign re       = (state == S_SCAN) && (scan_cnt < fill);
  assign out_free = !rsp_valid || !rsp_stall;

  assign cmd_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= key;
    end
    if (re) begin
      rd_data <= mem[scan_pos];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      fill      <= '0;
      rd_pend   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            op    <= cmd.opcode;
            key   <= cmd.value;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          hits       <= '0;
          res_status <= ST_DONE;
          rd_pend    <= 1'b0;
          scan_pos   <= front;
          scan_cnt   <= '0;
          state      <= S_DONE;
          unique case (op)
            OP_PUSH_FRONT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                front <= front_dec;
                fill  <= fill + 1'b1;
              end
            end
            OP_PUSH_BACK: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                fill <= fill + 1'b1;
              end
            end
            OP_DROP_FRONT: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                front <= front_inc;
                fill  <= fill - 1'b1;
              end
            end
            OP_DROP_BACK: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                fill <= fill - 1'b1;
              end
            end
            OP_COUNT: begin
              state <= S_SCAN;
            end
            default: begin
            end
          endcase
        end
        S_SCAN: begin
          rd_pend <= re;
          if (re) begin
            scan_pos <= scan_inc;
            scan_cnt <= scan_cnt + 1'b1;
          end
          if (rd_pend && rd_data == key && hits != COUNT_MAX) begin
            hits <= hits + 1'b1;
          end
          if (!re && !rd_pend) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            rsp.status      <= res_status;
            rsp.match_count <= hits;
            state           <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
